>>> hw/rtl/aclf_pkg.sv
// shared types, constants and register codes for the audio capture level framer
package aclf_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int TERM_W          = SAMPLE_W + 1;
    localparam int LEVEL_W         = 24;
    localparam int TOTAL_W         = 32;
    localparam int FLEN_W          = 13;
    localparam int FPOS_W          = 12;
    localparam int WEIGHT_W        = 9;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;

    localparam int S_TDATA_W       = 32;
    localparam int S_TUSER_W       = 3;
    localparam int M_TDATA_W       = 88;
    localparam int M_TUSER_W       = 2;

    localparam int MAX_CHANNELS_DEF        = 2;
    localparam int LEVEL_FRACTION_BITS_DEF = 8;

    localparam logic [FLEN_W-1:0]   FRAME_LENGTH_RST   = 13'd480;
    localparam logic [TOTAL_W-1:0]  SAMPLE_LIMIT_RST   = 32'd17280000;
    localparam logic [WEIGHT_W-1:0] RELEASE_WEIGHT_RST = 9'd38;

    localparam logic [FLEN_W-1:0]   FRAME_LENGTH_MAX   = 13'd4096;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL        = 9'd256;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX          = 24'hFFFFFF;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX          = 32'hFFFFFFFF;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_WEIGHT = 2'd2;

    typedef logic signed [TERM_W-1:0] term_t;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] mono;
        logic [SAMPLE_W-1:0] mag;
        logic                fmt;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [FLEN_W-1:0]   frame_length;
        logic [TOTAL_W-1:0]  sample_limit;
        logic [WEIGHT_W-1:0] release_weight;
    } cfg_t;

endpackage

>>> hw/rtl/audio_capture_level_framer.sv
// top level of the audio capture level framer
// throughput: one item per cycle while m_tready is high, set by the state update in the core
// the channel lanes and the merge stage form the first register stage, the core the second
// reset (rst_n low, asynchronous) clears all block state and both valid flags
// and loads the register defaults; no clearing pass, items are taken right after reset
module audio_capture_level_framer #(
    parameter int MAX_CHANNELS        = aclf_pkg::MAX_CHANNELS_DEF,
    parameter int LEVEL_FRACTION_BITS = aclf_pkg::LEVEL_FRACTION_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [aclf_pkg::S_TDATA_W-1:0]   s_tdata,   // sample_first, sample_second
    input  logic [aclf_pkg::S_TUSER_W-1:0]   s_tuser,   // op, two_channels, format_ok
    input  logic                             s_tlast,   // last_of_block
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [aclf_pkg::M_TDATA_W-1:0]   m_tdata,   // mono_sample, frame_peak, level,
                                                        // total_samples
    output logic [aclf_pkg::M_TUSER_W-1:0]   m_tuser,   // accepted, level_valid
    output logic                             m_tlast,   // frame_last
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aclf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aclf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    aclf_pkg::term_t  lane_term [MAX_CHANNELS];
    aclf_pkg::item_t  item;
    aclf_pkg::cfg_t   cfg;
    logic             item_valid;
    logic             item_ready;

    logic [aclf_pkg::FLEN_W-1:0]   frame_length_reg;
    logic [aclf_pkg::TOTAL_W-1:0]  sample_limit_reg;
    logic [aclf_pkg::WEIGHT_W-1:0] release_weight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg   <= aclf_pkg::FRAME_LENGTH_RST;
            sample_limit_reg   <= aclf_pkg::SAMPLE_LIMIT_RST;
            release_weight_reg <= aclf_pkg::RELEASE_WEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aclf_pkg::REG_FRAME_LENGTH:
                begin
                    frame_length_reg <= cfg_data[aclf_pkg::FLEN_W-1:0];
                end
                aclf_pkg::REG_SAMPLE_LIMIT:
                begin
                    sample_limit_reg <= cfg_data[aclf_pkg::TOTAL_W-1:0];
                end
                aclf_pkg::REG_RELEASE_WEIGHT:
                begin
                    release_weight_reg <= cfg_data[aclf_pkg::WEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.frame_length   = frame_length_reg;
    assign cfg.sample_limit   = sample_limit_reg;
    assign cfg.release_weight = release_weight_reg;

    for (genvar k = 0; k < MAX_CHANNELS; k++)
    begin : g_lane
        aclf_lane u_lane
        (
            .sample (s_tdata[k*aclf_pkg::SAMPLE_W +: aclf_pkg::SAMPLE_W]),
            .enable ((k == 0) ? 1'b1 : s_tuser[1]),
            .term   (lane_term[k])
        );
    end

    aclf_merge #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .lane_term     (lane_term),
        .op            (s_tuser[0]),
        .two_channels  (s_tuser[1]),
        .format_ok     (s_tuser[2]),
        .last_of_block (s_tlast),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    aclf_core #(
        .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
    ) u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (item_valid),
        .in_ready (item_ready),
        .item     (item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hw/rtl/aclf_lane.sv
// one channel lane: sign extension and gating of a channel sample
module aclf_lane
(
    input  logic [aclf_pkg::SAMPLE_W-1:0] sample,
    input  logic                          enable,
    output aclf_pkg::term_t               term
);

    always_comb
    begin
        if (enable)
        begin
            term = {sample[aclf_pkg::SAMPLE_W-1], sample};
        end
        else
        begin
            term = '0;
        end
    end

endmodule

>>> hw/rtl/aclf_merge.sv
// merge stage: sums the lanes, downmixes, takes the magnitude and registers the item
module aclf_merge #(
    parameter int MAX_CHANNELS = aclf_pkg::MAX_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  aclf_pkg::term_t       lane_term [MAX_CHANNELS],
    input  logic                  op,
    input  logic                  two_channels,
    input  logic                  format_ok,
    input  logic                  last_of_block,
    output logic                  item_valid,
    input  logic                  item_ready,
    output aclf_pkg::item_t       item
);

    logic                          valid_reg;
    logic                          valid_next;
    aclf_pkg::item_t               item_reg;
    aclf_pkg::term_t               sum;
    aclf_pkg::term_t               half;
    logic                          stereo;
    logic [aclf_pkg::SAMPLE_W-1:0] mono;
    logic [aclf_pkg::SAMPLE_W-1:0] mag;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            sum = sum + lane_term[k];
        end
    end

    // halve toward zero
    assign stereo = two_channels && (MAX_CHANNELS >= 2);
    assign half   = (sum + aclf_pkg::term_t'({{(aclf_pkg::TERM_W-1){1'b0}}, sum[aclf_pkg::TERM_W-1]}))
                    >>> 1;
    assign mono   = stereo ? half[aclf_pkg::SAMPLE_W-1:0] : sum[aclf_pkg::SAMPLE_W-1:0];
    assign mag    = mono[aclf_pkg::SAMPLE_W-1] ? (~mono + 1'b1) : mono;

    assign in_ready   = !valid_reg || item_ready;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op   <= op;
            item_reg.mono <= mono;
            item_reg.mag  <= mag;
            item_reg.fmt  <= format_ok;
            item_reg.last <= last_of_block;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hw/rtl/aclf_core.sv
// framing, block accept logic, level meter and output register
module aclf_core #(
    parameter int LEVEL_FRACTION_BITS = aclf_pkg::LEVEL_FRACTION_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  aclf_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  aclf_pkg::item_t                item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [aclf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [aclf_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);

    localparam int PW = aclf_pkg::SAMPLE_W + LEVEL_FRACTION_BITS;
    localparam int CW = (PW > aclf_pkg::LEVEL_W) ? PW : aclf_pkg::LEVEL_W;
    localparam int PROD_W = aclf_pkg::LEVEL_W + aclf_pkg::WEIGHT_W;

    logic [aclf_pkg::SAMPLE_W-1:0] bpeak_reg, bpeak_next;
    logic [aclf_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic [aclf_pkg::FPOS_W-1:0]   fpos_reg, fpos_next;
    logic [aclf_pkg::SAMPLE_W-1:0] rfp_reg, rfp_next;
    logic [aclf_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic                          finished_reg, finished_next;
    logic                          mid_reg, mid_next;
    logic                          drop_reg, drop_next;
    logic                          ovalid_reg, ovalid_next;
    logic [aclf_pkg::M_TDATA_W-1:0] odata_reg, odata_next;
    logic [aclf_pkg::M_TUSER_W-1:0] ouser_reg, ouser_next;
    logic                           olast_reg, olast_next;

    logic [aclf_pkg::FLEN_W-1:0]   flen;
    logic [aclf_pkg::WEIGHT_W-1:0] weight;
    logic                          fire;
    logic                          dropping;
    logic [aclf_pkg::SAMPLE_W-1:0] bp;
    logic [aclf_pkg::SAMPLE_W-1:0] rfp_v;
    logic [aclf_pkg::FLEN_W-1:0]   pos;
    logic [aclf_pkg::TOTAL_W:0]    tsum;
    logic                          acc;
    logic [aclf_pkg::SAMPLE_W-1:0] mono_o;
    logic                          flast;
    logic [aclf_pkg::SAMPLE_W-1:0] fpeak;
    logic                          lvalid;
    logic [PW-1:0]                 p;
    logic [CW-1:0]                 p_ext;
    logic [CW-1:0]                 lvl_ext;
    logic [aclf_pkg::LEVEL_W-1:0]  diff;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-1:0]             rel_acc;

    // out-of-range settings clamp
    always_comb
    begin
        if (cfg.frame_length == '0)
        begin
            flen = aclf_pkg::FLEN_W'(1);
        end
        else if (cfg.frame_length > aclf_pkg::FRAME_LENGTH_MAX)
        begin
            flen = aclf_pkg::FRAME_LENGTH_MAX;
        end
        else
        begin
            flen = cfg.frame_length;
        end
        weight = (cfg.release_weight > aclf_pkg::WEIGHT_FULL) ? aclf_pkg::WEIGHT_FULL
                                                              : cfg.release_weight;
    end

    assign in_ready = !ovalid_reg || m_tready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        bpeak_next    = bpeak_reg;
        level_next    = level_reg;
        fpos_next     = fpos_reg;
        rfp_next      = rfp_reg;
        total_next    = total_reg;
        finished_next = finished_reg;
        mid_next      = mid_reg;
        drop_next     = drop_reg;
        dropping      = drop_reg;
        bp            = bpeak_reg;
        rfp_v         = rfp_reg;
        pos           = {1'b0, fpos_reg} + aclf_pkg::FLEN_W'(1);
        tsum          = {1'b0, total_reg} + (aclf_pkg::TOTAL_W + 1)'(flen);
        acc           = 1'b0;
        mono_o        = '0;
        flast         = 1'b0;
        fpeak         = '0;
        lvalid        = 1'b0;
        p             = '0;
        p_ext         = '0;
        lvl_ext       = '0;
        diff          = '0;
        prod          = '0;
        rel_acc       = '0;

        if (item.op == aclf_pkg::OP_FINISH)
        begin
            finished_next = 1'b1;
            mid_next      = 1'b0;
            drop_next     = 1'b0;
            bpeak_next    = '0;
        end
        else
        begin
            // accept or drop is settled at the first instant of a block
            if (!mid_reg)
            begin
                bp       = '0;
                dropping = finished_reg || !item.fmt || (total_reg >= cfg.sample_limit);
            end

            if (!dropping)
            begin
                acc    = 1'b1;
                mono_o = item.mono;
                if (item.mag > bp)
                begin
                    bp = item.mag;
                end
                if (item.mag > rfp_v)
                begin
                    rfp_v = item.mag;
                end
                if (pos >= flen)
                begin
                    flast     = 1'b1;
                    fpeak     = rfp_v;
                    fpos_next = '0;
                    rfp_next  = '0;
                    total_next = tsum[aclf_pkg::TOTAL_W] ? aclf_pkg::TOTAL_MAX
                                                          : tsum[aclf_pkg::TOTAL_W-1:0];
                end
                else
                begin
                    fpos_next = pos[aclf_pkg::FPOS_W-1:0];
                    rfp_next  = rfp_v;
                end
            end

            if (item.last)
            begin
                if (!dropping)
                begin
                    // instant attack, weighted release rounded half up
                    p       = PW'(bp) << LEVEL_FRACTION_BITS;
                    p_ext   = CW'(p);
                    lvl_ext = CW'(level_reg);
                    diff    = level_reg - p_ext[aclf_pkg::LEVEL_W-1:0];
                    prod    = PROD_W'(diff) * PROD_W'(weight);
                    rel_acc = {1'b0, level_reg, 8'd0} + PROD_W'(128) - prod;
                    if (p_ext > lvl_ext)
                    begin
                        if (p_ext > CW'(aclf_pkg::LEVEL_MAX))
                        begin
                            level_next = aclf_pkg::LEVEL_MAX;
                        end
                        else
                        begin
                            level_next = p_ext[aclf_pkg::LEVEL_W-1:0];
                        end
                    end
                    else
                    begin
                        level_next = rel_acc[8 +: aclf_pkg::LEVEL_W];
                    end
                    lvalid = 1'b1;
                end
                mid_next   = 1'b0;
                drop_next  = 1'b0;
                bpeak_next = '0;
            end
            else
            begin
                mid_next   = 1'b1;
                drop_next  = dropping;
                bpeak_next = bp;
            end
        end

        odata_next  = {total_next, level_next, fpeak, mono_o};
        ouser_next  = {lvalid, acc};
        olast_next  = flast;
        ovalid_next = fire ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpeak_reg    <= '0;
            level_reg    <= '0;
            fpos_reg     <= '0;
            rfp_reg      <= '0;
            total_reg    <= '0;
            finished_reg <= 1'b0;
            mid_reg      <= 1'b0;
            drop_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (fire)
            begin
                bpeak_reg    <= bpeak_next;
                level_reg    <= level_next;
                fpos_reg     <= fpos_next;
                rfp_reg      <= rfp_next;
                total_reg    <= total_next;
                finished_reg <= finished_next;
                mid_reg      <= mid_next;
                drop_reg     <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            odata_reg <= odata_next;
            ouser_reg <= ouser_next;
            olast_reg <= olast_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

>>> hw/rtl/aclf_checker.sv
// port checker for the audio capture level framer, bound to the top level
module aclf_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [aclf_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [aclf_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           m_tlast
);

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    // refused sample carries no sample, frame or level event
    a_refused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0 && m_tdata[31:16] == 16'd0
                                    && !m_tlast && !m_tuser[1])
        else $error("refused item shows sample data");

    // a frame only completes on an accepted sample
    a_frame_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end on refused item");

    // frame peak is zero off frame ends
    a_peak_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[31:16] == 16'd0)
        else $error("frame peak outside frame end");

endmodule

bind audio_capture_level_framer aclf_checker u_aclf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/sv/tb_audio_capture_level_framer.sv
// self-checking testbench for the audio capture level framer, with its own level and frame predictor
`timescale 1ns / 100ps

module tb_audio_capture_level_framer;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;

    typedef struct packed {
        logic                                 op;
        logic signed [aclf_pkg::SAMPLE_W-1:0] first;
        logic signed [aclf_pkg::SAMPLE_W-1:0] second;
        logic                                 stereo;
        logic                                 fmt;
        logic                                 last;
    } capture_item_t;

    typedef struct packed {
        logic                          accepted;
        logic [aclf_pkg::SAMPLE_W-1:0] mono;
        logic                          frame_last;
        logic [aclf_pkg::SAMPLE_W-1:0] frame_peak;
        logic                          level_valid;
        logic [aclf_pkg::LEVEL_W-1:0]  level;
        logic [aclf_pkg::TOTAL_W-1:0]  total;
    } meter_result_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [aclf_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [aclf_pkg::S_TUSER_W-1:0]   s_tuser   = '0;
    logic                             s_tlast   = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [aclf_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [aclf_pkg::M_TUSER_W-1:0]   m_tuser;
    logic                             m_tlast;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [aclf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [aclf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies
    logic [aclf_pkg::FLEN_W-1:0]   cur_flen   = aclf_pkg::FRAME_LENGTH_RST;
    logic [aclf_pkg::TOTAL_W-1:0]  cur_limit  = aclf_pkg::SAMPLE_LIMIT_RST;
    logic [aclf_pkg::WEIGHT_W-1:0] cur_weight = aclf_pkg::RELEASE_WEIGHT_RST;

    // predicted block state
    int unsigned                  pk_block      = 0;
    logic [aclf_pkg::LEVEL_W-1:0] lvl_value     = '0;
    int unsigned                  frm_pos       = 0;
    int unsigned                  frm_peak      = 0;
    logic [aclf_pkg::TOTAL_W-1:0] framed_count  = '0;
    logic                         capture_done  = 1'b0;
    logic                         in_block      = 1'b0;
    logic                         block_refused = 1'b0;

    meter_result_t meter_expected[$];
    int            fail_count  = 0;
    int            items_sent  = 0;
    int            quiet_cycles = 0;
    logic          calm        = 1'b0;
    logic          long_hold   = 1'b0;

    audio_capture_level_framer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic predict_meter(input capture_item_t it);
        meter_result_t   r;
        int              s;
        int unsigned     mag;
        int unsigned     flen;
        int unsigned     pos;
        longint unsigned p;
        longint unsigned w;
        longint unsigned nv;
        longint unsigned t;
        r = '0;
        if (it.op == aclf_pkg::OP_FINISH)
        begin
            capture_done  = 1'b1;
            in_block      = 1'b0;
            block_refused = 1'b0;
            pk_block      = 0;
        end
        else
        begin
            if (!in_block)
            begin
                in_block      = 1'b1;
                pk_block      = 0;
                block_refused = capture_done || !it.fmt || framed_count >= cur_limit;
            end
            if (!block_refused)
            begin
                s    = it.stereo ? (int'(it.first) + int'(it.second)) / 2 : int'(it.first);
                mag  = (s < 0) ? -s : s;
                flen = (cur_flen == 0) ? 1 :
                       (cur_flen > aclf_pkg::FRAME_LENGTH_MAX ? aclf_pkg::FRAME_LENGTH_MAX
                                                              : cur_flen);
                r.accepted = 1'b1;
                r.mono     = 16'(s);
                if (mag > pk_block)
                    pk_block = mag;
                if (mag > frm_peak)
                    frm_peak = mag;
                pos = frm_pos + 1;
                if (pos >= flen)
                begin
                    t            = 64'(framed_count) + 64'(flen);
                    r.frame_last = 1'b1;
                    r.frame_peak = 16'(frm_peak);
                    framed_count = (t > aclf_pkg::TOTAL_MAX) ? aclf_pkg::TOTAL_MAX
                                                             : t[aclf_pkg::TOTAL_W-1:0];
                    frm_pos      = 0;
                    frm_peak     = 0;
                end
                else
                    frm_pos = pos & 32'hFFF;
            end
            if (it.last)
            begin
                if (!block_refused)
                begin
                    // instant attack, rounded weighted release otherwise
                    p = 64'(pk_block) << aclf_pkg::LEVEL_FRACTION_BITS_DEF;
                    w = (cur_weight > aclf_pkg::WEIGHT_FULL) ? aclf_pkg::WEIGHT_FULL
                                                             : cur_weight;
                    if (p > lvl_value)
                        nv = p;
                    else
                        nv = (64'(lvl_value) * (256 - w) + p * w + 128) >> 8;
                    lvl_value     = (nv > aclf_pkg::LEVEL_MAX) ? aclf_pkg::LEVEL_MAX
                                                               : nv[aclf_pkg::LEVEL_W-1:0];
                    r.level_valid = 1'b1;
                end
                in_block      = 1'b0;
                block_refused = 1'b0;
                pk_block      = 0;
            end
        end
        r.level = lvl_value;
        r.total = framed_count;
        meter_expected.insert(meter_expected.size(), r);
    endtask

    function automatic logic signed [aclf_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            4, 5:    return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 511)) - 256);
        endcase
    endfunction

    task automatic send_item(input capture_item_t it);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.second, it.first};
        s_tuser  <= {it.fmt, it.stereo, it.op};
        s_tlast  <= it.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_meter(it);
        items_sent++;
    endtask

    task automatic send_sample(input logic signed [aclf_pkg::SAMPLE_W-1:0] first,
                               input logic signed [aclf_pkg::SAMPLE_W-1:0] second,
                               input logic stereo, input logic fmt, input logic last);
        capture_item_t it;
        it.op     = aclf_pkg::OP_SAMPLE;
        it.first  = first;
        it.second = second;
        it.stereo = stereo;
        it.fmt    = fmt;
        it.last   = last;
        send_item(it);
    endtask

    task automatic send_finish(input logic last);
        capture_item_t it;
        it.op     = aclf_pkg::OP_FINISH;
        it.first  = rand_sample();
        it.second = rand_sample();
        it.stereo = 1'($urandom_range(0, 1));
        it.fmt    = 1'($urandom_range(0, 1));
        it.last   = last;
        send_item(it);
    endtask

    task automatic send_block(input int len, input logic fmt_first, input logic close);
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
                        (i == 0) ? fmt_first : 1'($urandom_range(0, 1)),
                        close && (i == len - 1));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (meter_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [aclf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [aclf_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            aclf_pkg::REG_FRAME_LENGTH:   cur_flen   = val[aclf_pkg::FLEN_W-1:0];
            aclf_pkg::REG_SAMPLE_LIMIT:   cur_limit  = val;
            aclf_pkg::REG_RELEASE_WEIGHT: cur_weight = val[aclf_pkg::WEIGHT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 4);
        send_sample(32767, 0, 1'b0, 1'b1, 1'b1);
        send_sample(-32768, 0, 1'b0, 1'b1, 1'b1);
        send_sample(-32768, -32768, 1'b1, 1'b1, 1'b0);
        send_sample(32767, 32767, 1'b1, 1'b1, 1'b0);
        send_sample(-1, 0, 1'b1, 1'b1, 1'b0);
        send_sample(-3, 0, 1'b1, 1'b1, 1'b0);
        send_sample(32767, -32768, 1'b1, 1'b1, 1'b0);
        send_sample(100, -32768, 1'b0, 1'b1, 1'b1);
        // bad format at block start drops the whole block
        send_sample(5, 0, 1'b0, 1'b0, 1'b0);
        send_sample(6, 0, 1'b0, 1'b1, 1'b0);
        send_sample(7, 0, 1'b0, 1'b1, 1'b1);
        // format only matters at the first instant
        send_sample(1000, 0, 1'b0, 1'b1, 1'b0);
        send_sample(-2000, 0, 1'b0, 1'b0, 1'b0);
        send_sample(3000, 1, 1'b1, 1'b0, 1'b1);
        send_sample(0, 0, 1'b0, 1'b1, 1'b1);
        send_sample(-16384, 16383, 1'b1, 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_frame_lengths();
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 0);
        send_block(3, 1'b1, 1'b1);
        settle();
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 1);
        send_block(2, 1'b1, 1'b1);
        settle();
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 7);
        send_block(5, 1'b1, 1'b1);
        settle();
        // shorter than the current position, frame closes on the next sample
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 3);
        send_block(2, 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_release_weights();
        logic [aclf_pkg::WEIGHT_W-1:0] weights[4];
        weights = '{9'd0, 9'd256, 9'd511, 9'd100};
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 5);
        foreach (weights[k])
        begin
            write_reg(aclf_pkg::REG_RELEASE_WEIGHT, weights[k]);
            send_sample(32767, 0, 1'b0, 1'b1, 1'b0);
            send_sample(-20000, 0, 1'b0, 1'b1, 1'b1);
            send_sample(8000, 0, 1'b0, 1'b1, 1'b1);
            send_sample(-500, 600, 1'b1, 1'b1, 1'b1);
            send_sample(0, 0, 1'b0, 1'b1, 1'b1);
            settle();
        end
    endtask

    task automatic test_sample_limit();
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 2);
        write_reg(aclf_pkg::REG_SAMPLE_LIMIT, framed_count + 4);
        repeat (5) send_block(3, 1'b1, 1'b1);
        settle();
        write_reg(aclf_pkg::REG_SAMPLE_LIMIT, 0);
        send_block(3, 1'b1, 1'b1);
        settle();
        write_reg(aclf_pkg::REG_SAMPLE_LIMIT, 32'hFFFF_FFFF);
        send_block(3, 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_backpressure();
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 3);
        long_hold = 1'b1;
        repeat (5) send_block($urandom_range(3, 10), 1'b1, 1'b1);
        // sender waits for every result before going on
        s_tvalid <= 1'b0;
        while (meter_expected.size() != 0)
            @(posedge clk);
        repeat (4) send_block($urandom_range(1, 8), 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_long_frame();
        int target;
        // above the maximum acts as the maximum
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 13'h1FFF);
        target = items_sent + 40;
        while (items_sent < target)
            send_block($urandom_range(5, 20), 1'b1, 1'b1);
        settle();
    endtask

    task automatic test_random();
        int target;
        for (int phase = 0; phase < 4; phase++)
        begin
            if ($urandom_range(0, 3) == 0)
                write_reg(aclf_pkg::REG_FRAME_LENGTH, 480);
            else
                write_reg(aclf_pkg::REG_FRAME_LENGTH, $urandom_range(1, 16));
            write_reg(aclf_pkg::REG_RELEASE_WEIGHT, $urandom_range(0, 511));
            if (phase == 1)
                write_reg(aclf_pkg::REG_SAMPLE_LIMIT, framed_count + $urandom_range(20, 80));
            else
                write_reg(aclf_pkg::REG_SAMPLE_LIMIT, 32'hFFFF_FFFF);
            if (phase == 3)
                calm = 1'b1;
            target = items_sent + 90;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_block($urandom_range(1, 12), 1'($urandom_range(0, 9) != 0), 1'b1);
                else
                    send_block($urandom_range(1, 6), 1'b0, 1'b1);
            end
            settle();
        end
    endtask

    task automatic test_finish();
        write_reg(aclf_pkg::REG_FRAME_LENGTH, 4);
        send_block(3, 1'b1, 1'b0);
        send_finish(1'b0);
        send_block(4, 1'b1, 1'b1);
        send_finish(1'b1);
        send_block(3, 1'b1, 1'b1);
        send_finish(1'($urandom_range(0, 1)));
        send_block(2, 1'b1, 1'b0);
        settle();
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        meter_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (meter_expected.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h %h %b",
                         $time, m_tdata, m_tuser, m_tlast);
                fail_count++;
            end
            else
            begin
                want = meter_expected.pop_front();
                check_field("accepted", want.accepted, m_tuser[0]);
                check_field("mono_sample", want.mono, m_tdata[15:0]);
                check_field("frame_last", want.frame_last, m_tlast);
                check_field("frame_peak", want.frame_peak, m_tdata[31:16]);
                check_field("level_valid", want.level_valid, m_tuser[1]);
                check_field("level", want.level, m_tdata[55:32]);
                check_field("total_samples", want.total, m_tdata[87:56]);
            end
        end
    end

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("audio_capture_level_framer test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_frame_lengths();
        test_release_weights();
        test_sample_limit();
        test_backpressure();
        test_long_frame();
        test_random();
        test_finish();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("audio_capture_level_framer test passed");
        else
            $display("audio_capture_level_framer test failed");
        $finish;
    end

endmodule
